// ===== hdl/big_endian_bounded_memory_port_assert.svh =====
// assertion macros for the big-endian memory port
// used by the top level only, needs nothing else
`ifndef BIG_ENDIAN_BOUNDED_MEMORY_PORT_ASSERT_SVH
`define BIG_ENDIAN_BOUNDED_MEMORY_PORT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked only out of reset
`define BEBMP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked only out of reset
`define BEBMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BEBMP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BEBMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/bebmp_pkg.sv =====
// shared types and constants of the big-endian memory port
// no dependencies
`timescale 1ns / 1ps

package bebmp_pkg;

	localparam int unsigned SLOT_BYTES_DEF     = 4096;
	localparam int unsigned MAX_SLOT_COUNT_DEF = 16;
	localparam int unsigned NUM_BANKS          = 4;

	// active slot count after reset
	localparam logic [4:0] ACTIVE_SLOTS_RST = 5'd16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_STORE = 1'b1;

	localparam logic [1:0] SZ_NONE = 2'd0;
	localparam logic [1:0] SZ_BYTE = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;
	localparam logic [1:0] SZ_LONG = 2'd3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SIZE = 2'd1,
		ST_BAD_ADDR = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage

// ===== hdl/bebmp_bank.sv =====
// one byte-wide bank of the interleaved ram, one write and one read port
// depends on bebmp_pkg for default sizes
`timescale 1ns / 1ps

module bebmp_bank #(
	parameter int unsigned DEPTH = bebmp_pkg::SLOT_BYTES_DEF * bebmp_pkg::MAX_SLOT_COUNT_DEF
		/ bebmp_pkg::NUM_BANKS,
	parameter int unsigned ROW_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [ROW_W-1:0] wr_row,
	input  logic [7:0]       wr_data,
	input  logic             rd_en,
	input  logic [ROW_W-1:0] rd_row,
	output logic [7:0]       rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
	end

	// registered read, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule

// ===== hdl/big_endian_bounded_memory_port.sv =====
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  opcode, operand_size, address, store_data
// out      out  out_valid/out_stall load_data, status
// cfg      in   cfg_valid/cfg_ready cfg_data (active slot count)
//
// one item per cycle when out_stall is low and the clearing pass is done; a result
// is offered after its item passes the bank read register, then the output register.
// ram is four byte banks interleaved on the low address bits, so any two- or
// four-byte span is one row access per bank. after reset a clearing pass zeroes one
// row per cycle, MAX_SLOT_COUNT*SLOT_BYTES/4 rows (16384 by default), while in_stall
// stays high; cfg writes are always taken. a held result stalls the input only when
// the read stage is also full. depends on bebmp_pkg, bebmp_bank and the assertion header
`timescale 1ns / 1ps
`include "big_endian_bounded_memory_port_assert.svh"

module big_endian_bounded_memory_port #(
	parameter int unsigned SLOT_BYTES     = bebmp_pkg::SLOT_BYTES_DEF,
	parameter int unsigned MAX_SLOT_COUNT = bebmp_pkg::MAX_SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [1:0]  operand_size,
	input  logic [31:0] address,
	input  logic [31:0] store_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] load_data,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	localparam int unsigned NB         = bebmp_pkg::NUM_BANKS;
	localparam int unsigned DEPTH      = SLOT_BYTES * MAX_SLOT_COUNT;
	localparam int unsigned BANK_DEPTH = DEPTH / NB;
	localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int unsigned LIMIT_W    = $clog2(DEPTH + 1);
	localparam int unsigned SLOT_W     = $clog2(MAX_SLOT_COUNT + 1);
	localparam int unsigned RST_SLOTS  =
		(32'(bebmp_pkg::ACTIVE_SLOTS_RST) > MAX_SLOT_COUNT) ? MAX_SLOT_COUNT
		: 32'(bebmp_pkg::ACTIVE_SLOTS_RST);
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(RST_SLOTS * SLOT_BYTES);
	localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(BANK_DEPTH - 1);

	// ram size register, set by cfg writes
	logic [LIMIT_W-1:0] limit_q;
	logic [SLOT_W-1:0]  slots_sat;
	logic               cfg_accept;

	// clearing pass
	logic               clr_active_q;
	logic [ROW_W-1:0]   clr_row_q;

	// input side
	logic               in_accept;
	bebmp_pkg::status_t chk_status;
	logic [32:0]        addr_end;
	logic [1:0]         a_lo;
	logic [ROW_W-1:0]   base_row;

	// per-bank ports
	logic [ROW_W-1:0]   bank_row  [NB];
	logic               bank_use  [NB];
	logic [7:0]         bank_wdat [NB];
	logic               wr_en     [NB];
	logic [ROW_W-1:0]   wr_row    [NB];
	logic [7:0]         wr_data   [NB];
	logic [7:0]         rd_data   [NB];

	// read stage
	logic               valid_s1;
	logic               op_s1;
	logic [1:0]         size_s1;
	logic [1:0]         alo_s1;
	bebmp_pkg::status_t status_s1;
	logic               s1_adv;
	logic [7:0]         ob [NB];
	logic [31:0]        result_s1;

	// output register
	logic               out_valid_q;
	logic [31:0]        load_data_q;
	bebmp_pkg::status_t status_q;

	// configuration
	assign cfg_ready  = 1'b1;
	assign cfg_accept = cfg_valid && cfg_ready;

	always_comb begin
		if (32'(cfg_data) > MAX_SLOT_COUNT) begin
			slots_sat = SLOT_W'(MAX_SLOT_COUNT);
		end else begin
			slots_sat = SLOT_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_accept) begin
			limit_q <= LIMIT_W'(32'(slots_sat) * SLOT_BYTES);
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_row_q    <= '0;
		end else if (clr_active_q) begin
			clr_row_q <= clr_row_q + ROW_W'(1);
			if (clr_row_q == LAST_ROW) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	// handshake
	assign s1_adv    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = clr_active_q || (valid_s1 && out_valid_q && out_stall);
	assign in_accept = in_valid && !in_stall;

	// checks, in priority order
	assign addr_end = {1'b0, address} + ((operand_size == bebmp_pkg::SZ_LONG) ? 33'd4 : 33'd2);

	always_comb begin
		if (operand_size == bebmp_pkg::SZ_NONE) begin
			chk_status = bebmp_pkg::ST_BAD_SIZE;
		end else if ({1'b0, address} >= 33'(limit_q)) begin
			chk_status = bebmp_pkg::ST_BAD_ADDR;
		end else if (addr_end > 33'(limit_q)) begin
			chk_status = bebmp_pkg::ST_OVERFLOW;
		end else begin
			chk_status = bebmp_pkg::ST_OK;
		end
	end

	// bank b holds byte offset (b - a_lo) mod 4; banks below a_lo sit one row further
	assign a_lo     = address[1:0];
	assign base_row = address[ROW_W+1:2];

	always_comb begin
		for (int b = 0; b < NB; b++) begin
			logic [1:0] k;
			k            = 2'(b) - a_lo;
			bank_row[b]  = base_row + ROW_W'(2'(b) < a_lo);
			bank_use[b]  = (operand_size == bebmp_pkg::SZ_LONG) || (k < 2'd2);
			if (operand_size == bebmp_pkg::SZ_LONG) begin
				bank_wdat[b] = store_data[8*(3-k) +: 8];
			end else if (k == 2'd0) begin
				bank_wdat[b] = (operand_size == bebmp_pkg::SZ_BYTE) ? 8'h00 : store_data[15:8];
			end else begin
				bank_wdat[b] = store_data[7:0];
			end
		end
	end

	always_comb begin
		for (int b = 0; b < NB; b++) begin
			if (clr_active_q) begin
				wr_en[b]   = 1'b1;
				wr_row[b]  = clr_row_q;
				wr_data[b] = 8'h00;
			end else begin
				wr_en[b]   = in_accept && (opcode == bebmp_pkg::OP_STORE)
					&& (chk_status == bebmp_pkg::ST_OK) && bank_use[b];
				wr_row[b]  = bank_row[b];
				wr_data[b] = bank_wdat[b];
			end
		end
	end

	for (genvar g = 0; g < NB; g++) begin : g_bank
		bebmp_bank #(
			.DEPTH (BANK_DEPTH),
			.ROW_W (ROW_W)
		) u_bank (
			.clk     (clk),
			.wr_en   (wr_en[g]),
			.wr_row  (wr_row[g]),
			.wr_data (wr_data[g]),
			.rd_en   (in_accept),
			.rd_row  (bank_row[g]),
			.rd_data (rd_data[g])
		);
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1     <= opcode;
			size_s1   <= operand_size;
			alo_s1    <= a_lo;
			status_s1 <= chk_status;
		end
	end

	// put bytes back in address order
	always_comb begin
		for (int k = 0; k < NB; k++) begin
			ob[k] = rd_data[2'(alo_s1 + 2'(k))];
		end
	end

	always_comb begin
		result_s1 = '0;
		if ((op_s1 == bebmp_pkg::OP_LOAD) && (status_s1 == bebmp_pkg::ST_OK)) begin
			case (size_s1)
				bebmp_pkg::SZ_LONG: result_s1 = {ob[0], ob[1], ob[2], ob[3]};
				bebmp_pkg::SZ_WORD: result_s1 = {16'h0000, ob[0], ob[1]};
				default:            result_s1 = {24'h000000, ob[1]};
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			load_data_q <= result_s1;
			status_q    <= status_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign load_data = load_data_q;
	assign status    = status_q;

	`BEBMP_ASSERT_IMP(a_no_item_while_clearing, clk, arst_n, clr_active_q, in_stall, "item taken during clearing pass")
	`BEBMP_ASSERT_NEXT(a_clear_runs_once, clk, arst_n, !clr_active_q, !clr_active_q, "clearing pass restarted")
	`BEBMP_ASSERT_IMP(a_failed_item_reads_zero, clk, arst_n, out_valid_q && (status_q != bebmp_pkg::ST_OK), load_data_q == 32'h0, "failed item returned data")
	`BEBMP_ASSERT_NEXT(a_accept_fills_read_stage, clk, arst_n, in_accept, valid_s1, "accepted item lost")

endmodule
